// ===== design/lacg_pkg.sv =====
// Shared types, constants and the sequencer microcode for the LPC access command generator.
package lacg_pkg;

    // Address space codes
    localparam logic [1:0] SPACE_IO  = 2'd0;
    localparam logic [1:0] SPACE_MEM = 2'd1;
    localparam logic [1:0] SPACE_FW  = 2'd2;
    localparam logic [1:0] SPACE_BAD = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_IO_BASE   = 2'd0;
    localparam logic [1:0] CFG_MEM_BASE  = 2'd1;
    localparam logic [1:0] CFG_FW_BASE   = 2'd2;
    localparam logic [1:0] CFG_HREG_BASE = 2'd3;

    // Configuration reset values
    localparam logic [31:0] IO_BASE_RST   = 32'hD001_0000;
    localparam logic [31:0] MEM_BASE_RST  = 32'hE000_0000;
    localparam logic [31:0] FW_BASE_RST   = 32'hF000_0000;
    localparam logic [31:0] HREG_BASE_RST = 32'hC001_2000;

    // Space limits, host controller register offsets and read size values
    localparam logic [31:0] IO_SPACE_TOP   = 32'h0001_0000;
    localparam logic [31:0] MEM_SPACE_TOP  = 32'h1000_0000;
    localparam logic [31:0] HREG_SEGMENT   = 32'h0000_0024;
    localparam logic [31:0] HREG_READ_SIZE = 32'h0000_0028;
    localparam logic [31:0] RSZ_HALF       = 32'h0100_0000;
    localparam logic [31:0] RSZ_WORD       = 32'h0200_0000;

    // Control word fixed fields
    localparam logic [3:0] CTL_MAGIC    = 4'hD;
    localparam logic [2:0] CTL_ADDR_LEN = 3'd4;
    localparam logic [2:0] SIZE_WORD    = 3'd4;

    typedef enum logic [2:0] {
        KIND_ACCESS    = 3'd0,
        KIND_SET_SEG   = 3'd1,
        KIND_READ_SIZE = 3'd2,
        KIND_REJECT    = 3'd3,
        KIND_DONE      = 3'd4
    } kind_t;

    // Datapath operation selected by a control word
    typedef enum logic [2:0] {
        UOP_PRE   = 3'd0,
        UOP_RANGE = 3'd1,
        UOP_SEG   = 3'd2,
        UOP_RSZ   = 3'd3,
        UOP_ACC   = 3'd4
    } uop_t;

    localparam int unsigned STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_PRE   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_RANGE = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_SEG   = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_RSZ   = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_ACC   = STEP_W'(4);

    typedef struct packed {
        uop_t              op;
        logic [STEP_W-1:0] next;
        logic [STEP_W-1:0] jump;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        logic start;
        logic advance;
        uop_t op;
    } seq_ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic slot_free;
        logic stop;
        logic loop;
    } dp_stat_t;

    // Microcode program: prechecks, range check, segment update, read size, access
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            STEP_PRE:   w = '{op: UOP_PRE,   next: STEP_RANGE, jump: STEP_PRE};
            STEP_RANGE: w = '{op: UOP_RANGE, next: STEP_SEG,   jump: STEP_PRE};
            STEP_SEG:   w = '{op: UOP_SEG,   next: STEP_RSZ,   jump: STEP_PRE};
            STEP_RSZ:   w = '{op: UOP_RSZ,   next: STEP_ACC,   jump: STEP_PRE};
            STEP_ACC:   w = '{op: UOP_ACC,   next: STEP_PRE,   jump: STEP_RANGE};
            default:    w = '{op: UOP_PRE,   next: STEP_PRE,   jump: STEP_PRE};
        endcase
        return w;
    endfunction

    // Bridge control word, msb-0 fields packed into 64 bits
    function automatic logic [63:0] make_ctl(input logic rd, input logic [2:0] sz,
                                             input logic [31:0] ba);
        return {CTL_MAGIC, 1'b0, sz, 7'b0, rd, 7'b0, CTL_ADDR_LEN, 6'b0, ba};
    endfunction

endpackage

// ===== design/lacg_ifs.sv =====
// Request and result channel interfaces.
interface lacg_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [1:0]  space;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [2:0]  size;
    logic        split_enable;

    modport source (output valid, func, space, address, write_data, size, split_enable,
                    input ready);
    modport sink   (input valid, func, space, address, write_data, size, split_enable,
                    output ready);
endinterface

interface lacg_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic        is_read;
    logic [31:0] bridge_address;
    logic [63:0] control_word;
    logic [63:0] data_word;
    logic [3:0]  segment_value;
    logic [4:0]  read_shift;
    logic        last;

    modport source (output valid, kind, is_read, bridge_address, control_word, data_word,
                    segment_value, read_shift, last, input ready);
    modport sink   (input valid, kind, is_read, bridge_address, control_word, data_word,
                    segment_value, read_shift, last, output ready);
endinterface

// ===== design/lpc_access_command_generator.sv =====
// Top level of the LPC access command generator.
// A request's first result is registered at the first microcode step that emits one.
// Throughput: one microcode step a cycle while the result register is free; a request runs
// a precheck step, then range, segment, read size and access steps for each access (one
// per byte when splitting); a new request is accepted only once the sequencer has stopped;
// a stalled result holds the sequencer. Reset clears config to defaults and both shadows to unknown.
module lpc_access_command_generator (
    input  logic        clk,
    input  logic        rst_n,
    lacg_req_if.sink    req,
    lacg_res_if.source  res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import lacg_pkg::*;

    seq_ctl_t ctl;
    dp_stat_t stat;
    logic     seq_ready;

    assign req.ready = seq_ready;

    lacg_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (seq_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    lacg_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .stat      (stat)
    );

endmodule

// ===== design/lacg_useq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
module lacg_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lacg_pkg::dp_stat_t  stat,
    output lacg_pkg::seq_ctl_t  ctl
);
    import lacg_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            uword;
    logic              accept;
    logic              advance;

    assign uword     = ucode_rom(step_reg);
    assign req_ready = !busy_reg;
    assign accept    = req_valid && !busy_reg;
    assign advance   = busy_reg && stat.slot_free;

    assign ctl.start   = accept;
    assign ctl.advance = advance;
    assign ctl.op      = uword.op;

    // Pick the next step: start at the precheck, stop, jump back for the next byte, or fall through
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = STEP_PRE;
        end
        else if (advance)
        begin
            if (stat.stop)
            begin
                busy_next = 1'b0;
                step_next = STEP_PRE;
            end
            else if (stat.loop)
                step_next = uword.jump;
            else
                step_next = uword.next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_PRE;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    a_start_at_pre: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && step_reg == STEP_PRE)
        else $error("sequence did not start at the first step");

    a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_ACC)
        else $error("step counter left the program");

    a_idle_only_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(advance && stat.stop))
        else $error("sequencer went idle without a stop");

endmodule

// ===== design/lacg_dpath.sv =====
// Datapath: request and config registers, checks, shadows and the result register.
module lacg_dpath (
    input  logic               clk,
    input  logic               rst_n,
    lacg_req_if.sink           req,
    lacg_res_if.source         res,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  lacg_pkg::seq_ctl_t ctl,
    output lacg_pkg::dp_stat_t stat
);
    import lacg_pkg::*;

    // Configuration
    logic [31:0] io_base_reg, mem_base_reg, fw_base_reg, hreg_base_reg;

    // Request
    logic        rd_reg;
    logic [1:0]  space_reg;
    logic [31:0] addr_reg;
    logic [31:0] wdata_reg;
    logic [2:0]  size_reg;
    logic        split_reg;
    logic [2:0]  count_reg;

    // Shadows
    logic [3:0] seg_shadow_reg;
    logic       seg_known_reg;
    logic [2:0] rsz_shadow_reg;
    logic       rsz_known_reg;

    // Result register
    logic        out_valid_reg;
    kind_t       kind_reg;
    logic        is_read_reg;
    logic [31:0] ba_reg;
    logic [63:0] cw_reg;
    logic [63:0] dw_reg;
    logic [3:0]  segv_reg;
    logic [4:0]  shift_reg;
    logic        last_reg;

    // Checks
    logic [2:0]  es;
    logic [32:0] top;
    logic [31:0] last_byte;
    logic [3:0]  seg;
    logic        range_bad;
    logic        bus_ok;
    logic        seg_miss;
    logic        rsz_miss;
    logic        is_fw;
    logic        more;
    logic [2:0]  count_m1;
    logic [31:0] win_base;
    logic [31:0] acc_addr;
    logic [31:0] hreg_addr;
    logic [31:0] rsz_value;

    // Result candidate
    logic        emit;
    logic        seg_upd;
    logic        rsz_upd;
    logic        seq_stop;
    logic        seq_loop;
    kind_t       r_kind;
    logic        r_is_read;
    logic [31:0] r_ba;
    logic [63:0] r_cw;
    logic [63:0] r_dw;
    logic [3:0]  r_segv;
    logic [4:0]  r_shift;
    logic        r_last;

    // Per-access size: one byte when splitting
    assign es        = split_reg ? 3'd1 : size_reg;
    assign top       = {1'b0, addr_reg} + {30'b0, es};
    assign last_byte = top[31:0] - 32'd1;
    assign seg       = addr_reg[31:28];
    assign is_fw     = space_reg == SPACE_FW;
    assign bus_ok    = es == 3'd1 || es == 3'd2 || es == 3'd4;
    assign seg_miss  = !(seg_known_reg && seg_shadow_reg == seg);
    assign rsz_miss  = rd_reg && !(rsz_known_reg && rsz_shadow_reg == es);
    assign more      = split_reg && count_reg > 3'd1;
    assign count_m1  = count_reg - 3'd1;

    // Range check per space
    always_comb
    begin
        range_bad = top[32];
        case (space_reg)
            SPACE_IO:  range_bad = range_bad || top[31:0] > IO_SPACE_TOP || es != 3'd1;
            SPACE_MEM: range_bad = range_bad || top[31:0] > MEM_SPACE_TOP || es != 3'd1;
            SPACE_FW:  range_bad = range_bad || last_byte[31:28] != seg;
            default:   range_bad = 1'b1;
        endcase
    end

    // Window base for the access
    always_comb
    begin
        case (space_reg)
            SPACE_IO:  win_base = io_base_reg;
            SPACE_MEM: win_base = mem_base_reg;
            default:   win_base = fw_base_reg;
        endcase
    end

    assign acc_addr  = win_base + addr_reg;
    assign hreg_addr = hreg_base_reg + ((ctl.op == UOP_SEG) ? HREG_SEGMENT : HREG_READ_SIZE);
    assign rsz_value = (es == 3'd1) ? 32'd0 : ((es == 3'd2) ? RSZ_HALF : RSZ_WORD);

    // Decode the current operation into a result and a sequencer decision
    always_comb
    begin
        emit      = 1'b0;
        seg_upd   = 1'b0;
        rsz_upd   = 1'b0;
        seq_stop  = 1'b0;
        seq_loop  = 1'b0;
        r_kind    = KIND_REJECT;
        r_is_read = 1'b0;
        r_ba      = '0;
        r_cw      = '0;
        r_dw      = '0;
        r_segv    = '0;
        r_shift   = '0;
        r_last    = 1'b1;
        unique case (ctl.op)
            UOP_PRE:
            begin
                if (split_reg && size_reg > 3'd4)
                begin
                    emit     = 1'b1;
                    seq_stop = 1'b1;
                end
                else if (split_reg && size_reg == 3'd0)
                begin
                    emit     = 1'b1;
                    seq_stop = 1'b1;
                    r_kind   = KIND_DONE;
                end
            end
            UOP_RANGE:
            begin
                if (range_bad)
                begin
                    emit     = 1'b1;
                    seq_stop = 1'b1;
                end
            end
            UOP_SEG:
            begin
                if (is_fw && seg_miss)
                begin
                    emit    = 1'b1;
                    seg_upd = 1'b1;
                    r_kind  = KIND_SET_SEG;
                    r_ba    = hreg_addr;
                    r_cw    = make_ctl(1'b0, SIZE_WORD, hreg_addr);
                    r_dw    = {28'b0, seg, 32'b0};
                    r_segv  = seg;
                    r_last  = 1'b0;
                end
            end
            UOP_RSZ:
            begin
                if (is_fw && rsz_miss)
                begin
                    emit = 1'b1;
                    if (!bus_ok)
                        seq_stop = 1'b1;
                    else
                    begin
                        rsz_upd = 1'b1;
                        r_kind  = KIND_READ_SIZE;
                        r_ba    = hreg_addr;
                        r_cw    = make_ctl(1'b0, SIZE_WORD, hreg_addr);
                        r_dw    = {rsz_value, 32'b0};
                        r_last  = 1'b0;
                    end
                end
            end
            UOP_ACC:
            begin
                emit = 1'b1;
                if (!bus_ok)
                    seq_stop = 1'b1;
                else
                begin
                    seq_loop  = more;
                    seq_stop  = !more;
                    r_kind    = KIND_ACCESS;
                    r_is_read = rd_reg;
                    r_ba      = acc_addr;
                    r_cw      = make_ctl(rd_reg, es, acc_addr);
                    r_last    = !more;
                    if (rd_reg && split_reg)
                        r_shift = {count_m1[1:0], 3'b000};
                    if (!rd_reg)
                    begin
                        case (es)
                            3'd1:    r_dw = {wdata_reg[7:0], 56'b0};
                            3'd2:    r_dw = {wdata_reg[15:0], 48'b0};
                            default: r_dw = {wdata_reg, 32'b0};
                        endcase
                    end
                end
            end
            default:
            begin
                seq_stop = 1'b1;
            end
        endcase
    end

    assign stat.slot_free = !out_valid_reg || res.ready;
    assign stat.stop      = seq_stop;
    assign stat.loop      = seq_loop;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            io_base_reg   <= IO_BASE_RST;
            mem_base_reg  <= MEM_BASE_RST;
            fw_base_reg   <= FW_BASE_RST;
            hreg_base_reg <= HREG_BASE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IO_BASE:   io_base_reg   <= cfg_data;
                CFG_MEM_BASE:  mem_base_reg  <= cfg_data;
                CFG_FW_BASE:   fw_base_reg   <= cfg_data;
                CFG_HREG_BASE: hreg_base_reg <= cfg_data;
                default:       io_base_reg   <= io_base_reg;
            endcase
        end
    end

    // Capture the request; advance address, data and byte count per split byte
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rd_reg    <= !req.func;
            space_reg <= req.space;
            addr_reg  <= req.address;
            wdata_reg <= req.write_data;
            size_reg  <= req.size;
            split_reg <= req.split_enable && req.space != SPACE_FW && req.size != 3'd1;
            count_reg <= req.size;
        end
        else if (ctl.advance && seq_loop)
        begin
            addr_reg  <= addr_reg + 32'd1;
            wdata_reg <= {8'b0, wdata_reg[31:8]};
            count_reg <= count_m1;
        end
    end

    // Shadows follow the emitted commands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_shadow_reg <= 4'd0;
            seg_known_reg  <= 1'b0;
            rsz_shadow_reg <= 3'd0;
            rsz_known_reg  <= 1'b0;
        end
        else if (ctl.advance)
        begin
            if (seg_upd)
            begin
                seg_shadow_reg <= seg;
                seg_known_reg  <= 1'b1;
            end
            if (rsz_upd)
            begin
                rsz_shadow_reg <= es;
                rsz_known_reg  <= 1'b1;
            end
        end
    end

    // Result valid: load on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.advance && emit)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (ctl.advance && emit)
        begin
            kind_reg    <= r_kind;
            is_read_reg <= r_is_read;
            ba_reg      <= r_ba;
            cw_reg      <= r_cw;
            dw_reg      <= r_dw;
            segv_reg    <= r_segv;
            shift_reg   <= r_shift;
            last_reg    <= r_last;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.kind           = kind_reg;
    assign res.is_read        = is_read_reg;
    assign res.bridge_address = ba_reg;
    assign res.control_word   = cw_reg;
    assign res.data_word      = dw_reg;
    assign res.segment_value  = segv_reg;
    assign res.read_shift     = shift_reg;
    assign res.last           = last_reg;

    a_seg_shadow_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(seg_shadow_reg) |-> out_valid_reg && kind_reg == KIND_SET_SEG)
        else $error("segment shadow changed without a set segment command");

    a_terminal_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == KIND_REJECT || kind_reg == KIND_DONE) |-> last_reg)
        else $error("reject or done result not marked last");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.advance && emit |-> !out_valid_reg || res.ready)
        else $error("result register overwritten while full");

endmodule
